>>> sv/lps_pkg.sv
// Shared types and constants for the line pixel stepper.
package lps_pkg;

  // Request kinds carried through the command queue
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } req_cmd_e;

  // Command queue geometry
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Queue occupancy status
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } q_status_t;

  // Stepper status
  typedef struct packed {
    logic busy;
    logic at_target;
  } back_status_t;

endpackage

>>> sv/lps_front.sv
// Front end: decodes a request and precomputes line setup for the queue.
module lps_front #(
  parameter  int unsigned CW      = 16,
  parameter  int unsigned CLW     = 16,
  localparam int unsigned ENTRY_W = 6 * CW + 6 + CLW
) (
  input  logic                 req_type_i,
  input  logic signed [CW-1:0] x_start_i,
  input  logic signed [CW-1:0] y_start_i,
  input  logic signed [CW-1:0] x_end_i,
  input  logic signed [CW-1:0] y_end_i,
  input  logic [CLW-1:0]       line_color_i,
  output logic [ENTRY_W-1:0]   entry_o
);
  import lps_pkg::*;

  req_cmd_e           cmd;
  logic signed [CW:0] ddx;
  logic signed [CW:0] ddy;
  logic [CW:0]        delta_x;
  logic [CW+1:0]      neg_delta_y;
  logic               step_x_neg;
  logic               step_y_neg;

  // Classify the beat
  assign cmd = req_type_i ? CMD_STEP : CMD_START;

  // Signed differences, one extra bit so they never wrap
  assign ddx = {x_end_i[CW-1], x_end_i} - {x_start_i[CW-1], x_start_i};
  assign ddy = {y_end_i[CW-1], y_end_i} - {y_start_i[CW-1], y_start_i};

  // |dx| and -|dy|
  always_comb begin
    delta_x     = ddx[CW] ? (CW+1)'(-ddx) : ddx;
    neg_delta_y = ddy[CW] ? {ddy[CW], ddy} : (CW+2)'(-{ddy[CW], ddy});
  end

  // Step direction; equal coordinates count as negative
  assign step_x_neg = !(x_start_i < x_end_i);
  assign step_y_neg = !(y_start_i < y_end_i);

  assign entry_o = {cmd, x_start_i, y_start_i, x_end_i, y_end_i,
                    delta_x, neg_delta_y, step_x_neg, step_y_neg, line_color_i};

endmodule

>>> sv/lps_queue.sv
// Short command queue between the front end and the stepper.
module lps_queue #(
  parameter int unsigned W = 118
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [W-1:0]        data_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                valid_o,
  output logic [W-1:0]        data_o,
  output lps_pkg::q_status_t  status_o
);
  import lps_pkg::*;

  logic [W-1:0]      slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign status_o.count = count_q;
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = !ready_o;

endmodule

>>> sv/lps_back.sv
// Back end: Bresenham stepper with the registered pixel output.
module lps_back #(
  parameter  int unsigned CW      = 16,
  parameter  int unsigned CLW     = 16,
  localparam int unsigned ENTRY_W = 6 * CW + 6 + CLW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   entry_valid_i,
  input  logic [ENTRY_W-1:0]     entry_i,
  output logic                   entry_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [CW-1:0]   pixel_x_o,
  output logic signed [CW-1:0]   pixel_y_o,
  output logic [CLW-1:0]         pixel_color_o,
  output logic                   last_o,
  output lps_pkg::back_status_t  status_o
);
  import lps_pkg::*;

  localparam int unsigned EW = CW + 3;

  // Unpacked queue entry
  logic          e_cmd_raw;
  req_cmd_e      e_cmd;
  logic [CW-1:0] e_x0, e_y0, e_x1, e_y1;
  logic [CW:0]   e_dx;
  logic [CW+1:0] e_ndy;
  logic          e_sxn, e_syn;
  logic [CLW-1:0] e_color;

  // Line state
  logic [CW-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CW-1:0]  tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [CW:0]    dx_q, dx_d;
  logic [CW+1:0]  ndy_q, ndy_d;
  logic           sxn_q, sxn_d, syn_q, syn_d;
  logic [EW-1:0]  err_q, err_d;
  logic [CLW-1:0] color_q, color_d;
  logic           busy_q, busy_d;

  // Output register
  logic           out_valid_q, out_valid_d;
  logic [CW-1:0]  pix_x_q, pix_y_q;
  logic [CLW-1:0] pix_color_q;
  logic           last_q;

  logic           is_start, slot_free, take, emit, done;
  logic signed [EW-1:0] e2, dx_ext, ndy_ext, e_dx_ext, e_ndy_ext;
  logic           mv_x, mv_y;

  assign {e_cmd_raw, e_x0, e_y0, e_x1, e_y1, e_dx, e_ndy, e_sxn, e_syn,
          e_color} = entry_i;
  assign e_cmd = req_cmd_e'(e_cmd_raw);

  // Issue control: an idle step retires without a beat
  assign is_start    = (e_cmd == CMD_START);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign take        = entry_valid_i && (slot_free || (!is_start && !busy_q));
  assign emit        = take && (is_start || busy_q);
  assign entry_pop_o = take;

  // Error term arithmetic, widened so doubling cannot overflow
  assign dx_ext    = {{(EW-CW-1){1'b0}}, dx_q};
  assign ndy_ext   = {ndy_q[CW+1], ndy_q};
  assign e_dx_ext  = {{(EW-CW-1){1'b0}}, e_dx};
  assign e_ndy_ext = {e_ndy[CW+1], e_ndy};
  assign e2        = {err_q[EW-2:0], 1'b0};
  assign mv_x      = (e2 >= ndy_ext);
  assign mv_y      = (e2 <= dx_ext);

  // Next line state
  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    tgt_x_d = tgt_x_q;
    tgt_y_d = tgt_y_q;
    dx_d    = dx_q;
    ndy_d   = ndy_q;
    sxn_d   = sxn_q;
    syn_d   = syn_q;
    err_d   = err_q;
    color_d = color_q;
    if (is_start) begin
      cur_x_d = e_x0;
      cur_y_d = e_y0;
      tgt_x_d = e_x1;
      tgt_y_d = e_y1;
      dx_d    = e_dx;
      ndy_d   = e_ndy;
      sxn_d   = e_sxn;
      syn_d   = e_syn;
      err_d   = e_dx_ext + e_ndy_ext;
      color_d = e_color;
    end else begin
      err_d = err_q + (mv_x ? ndy_ext : '0) + (mv_y ? dx_ext : '0);
      if (mv_x) begin
        cur_x_d = sxn_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
      end
      if (mv_y) begin
        cur_y_d = syn_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
    end
    done   = (cur_x_d == tgt_x_d) && (cur_y_d == tgt_y_d);
    busy_d = !done;
  end

  // Output valid: load on emit, clear when taken
  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      dx_q        <= '0;
      ndy_q       <= '0;
      sxn_q       <= 1'b0;
      syn_q       <= 1'b0;
      err_q       <= '0;
      color_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (emit) begin
        cur_x_q <= cur_x_d;
        cur_y_q <= cur_y_d;
        tgt_x_q <= tgt_x_d;
        tgt_y_q <= tgt_y_d;
        dx_q    <= dx_d;
        ndy_q   <= ndy_d;
        sxn_q   <= sxn_d;
        syn_q   <= syn_d;
        err_q   <= err_d;
        color_q <= color_d;
        busy_q  <= busy_d;
      end
    end
  end

  // Pixel payload, no reset
  always_ff @(posedge clk_i) begin
    if (emit) begin
      pix_x_q     <= cur_x_d;
      pix_y_q     <= cur_y_d;
      pix_color_q <= color_d;
      last_q      <= done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_color_o = pix_color_q;
  assign last_o        = last_q;

  assign status_o.busy      = busy_q;
  assign status_o.at_target = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);

endmodule

>>> sv/line_pixel_stepper_unit.sv
// Top level of the Bresenham line pixel stepper.
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one request per beat. A start
//   request (req_type_i = 0) loads both endpoints and a color and yields the
//   first pixel; a step request (req_type_i = 1) yields the next pixel. A step
//   with no line in progress yields nothing. A start always abandons any line
//   in progress.
//   Output channel (out_valid_o/out_ready_i) gives one pixel per beat with its
//   coordinates, the line color and last_o on the second endpoint.
// Timing:
//   A request lands in a two-entry command queue at the accepting edge; the
//   stepper retires it into the output register once that register is free.
//   The stepper does one add-compare error update per cycle, giving one
//   request and one pixel per clock in steady state while out_ready_i is high.
// Stall and reset:
//   When the receiver stalls, the pixel holds in the output register, the
//   stepper waits, and the queue absorbs up to two more requests before
//   in_ready_o drops. Reset empties the queue, clears the output and leaves
//   no line in progress.
module line_pixel_stepper_unit #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned COLOR_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  input  logic [COLOR_BITS-1:0]        line_color_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic [COLOR_BITS-1:0]        pixel_color_o,
  output logic                         last_o
);
  import lps_pkg::*;

  localparam int unsigned ENTRY_W = 6 * COORD_BITS + 6 + COLOR_BITS;

  logic [ENTRY_W-1:0] front_entry;
  logic [ENTRY_W-1:0] q_entry;
  logic               q_valid;
  logic               q_pop;
  q_status_t          q_status;
  back_status_t       b_status;

  // Request decode and line setup
  lps_front #(
    .CW  (COORD_BITS),
    .CLW (COLOR_BITS)
  ) u_front (
    .req_type_i   (req_type_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .line_color_i (line_color_i),
    .entry_o      (front_entry)
  );

  // Command queue
  lps_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_valid_i),
    .data_i   (front_entry),
    .ready_o  (in_ready_o),
    .pop_i    (q_pop),
    .valid_o  (q_valid),
    .data_o   (q_entry),
    .status_o (q_status)
  );

  // Stepper and output register
  lps_back #(
    .CW  (COORD_BITS),
    .CLW (COLOR_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (q_valid),
    .entry_i       (q_entry),
    .entry_pop_o   (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_o        (last_o),
    .status_o      (b_status)
  );

  // An accepted request is in the queue at the next edge
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !q_status.empty)
    else $error("accepted request missing from queue");

  // Idle stepper always sits on its target
  a_idle_at_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !b_status.busy |-> b_status.at_target)
    else $error("stepper idle away from target");

  // A pending last pixel means no line is in progress
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !b_status.busy)
    else $error("last pixel while line still busy");

  // Output beat loaded only when the queue supplied a request
  a_emit_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o ##1 out_valid_o |-> $past(q_valid))
    else $error("pixel without a queued request");

endmodule

>>> dv/tb_line_pixel_stepper_unit.sv
// Testbench for line_pixel_stepper_unit: random line requests checked against a Bresenham predictor.
module tb_line_pixel_stepper_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lps_pkg::*;

  localparam int CW          = 16;
  localparam int KW          = 16;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASE_ITEMS = 310;

  typedef struct {
    req_cmd_e               kind;
    logic signed [CW-1:0]   xs;
    logic signed [CW-1:0]   ys;
    logic signed [CW-1:0]   xe;
    logic signed [CW-1:0]   ye;
    logic [KW-1:0]          color;
  } line_req_t;

  typedef struct {
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic [KW-1:0]          color;
    logic                   last;
  } pixel_t;

  // DUT ports
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic                 req_type_i    = 1'b0;
  logic signed [CW-1:0] x_start_i     = '0;
  logic signed [CW-1:0] y_start_i     = '0;
  logic signed [CW-1:0] x_end_i       = '0;
  logic signed [CW-1:0] y_end_i       = '0;
  logic [KW-1:0]        line_color_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic signed [CW-1:0] pixel_x_o;
  logic signed [CW-1:0] pixel_y_o;
  logic [KW-1:0]        pixel_color_o;
  logic                 last_o;

  // Stimulus and scoreboard storage
  line_req_t req_q[$];
  pixel_t    pixel_q[$];
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        fail_cnt       = 0;
  int        quiet_cycles   = 0;

  // Rasterizer state mirror
  logic signed [CW-1:0] ln_cur_x, ln_cur_y, ln_tgt_x, ln_tgt_y;
  logic [CW:0]          ln_dx;
  logic signed [CW+1:0] ln_ndy;
  logic signed [CW+2:0] ln_err;
  logic                 ln_x_neg, ln_y_neg, ln_busy;
  logic [KW-1:0]        ln_color;

  // Monitor scratch
  bit        in_beat, out_beat, has_pix;
  line_req_t seen_req;
  pixel_t    pred_pix, got_pix, want_pix;

  line_pixel_stepper_unit #(
    .COORD_BITS (CW),
    .COLOR_BITS (KW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .line_color_i  (line_color_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_o        (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Bresenham predictor: advance the line by one request
  task automatic raster_advance(input line_req_t r, output bit emits, output pixel_t pix);
    int ddx, ddy, e2, err, ndy, adx;
    emits = 1'b0;
    if (r.kind == CMD_START) begin
      ddx      = int'(r.xe) - int'(r.xs);
      ddy      = int'(r.ye) - int'(r.ys);
      ln_cur_x = r.xs;
      ln_cur_y = r.ys;
      ln_tgt_x = r.xe;
      ln_tgt_y = r.ye;
      adx      = (ddx < 0) ? -ddx : ddx;
      ndy      = (ddy < 0) ? ddy : -ddy;
      ln_dx    = (CW+1)'(adx);
      ln_ndy   = (CW+2)'(ndy);
      ln_x_neg = !(r.xs < r.xe);
      ln_y_neg = !(r.ys < r.ye);
      ln_err   = (CW+3)'(adx + ndy);
      ln_color = r.color;
      ln_busy  = !(ln_cur_x == ln_tgt_x && ln_cur_y == ln_tgt_y);
      emits    = 1'b1;
    end else if (ln_busy) begin
      err = int'(ln_err);
      ndy = int'(ln_ndy);
      adx = int'(ln_dx);
      e2  = 2 * err;
      if (e2 >= ndy) begin
        err      = err + ndy;
        ln_cur_x = ln_cur_x + (ln_x_neg ? -16'sd1 : 16'sd1);
      end
      if (e2 <= adx) begin
        err      = err + adx;
        ln_cur_y = ln_cur_y + (ln_y_neg ? -16'sd1 : 16'sd1);
      end
      ln_err = (CW+3)'(err);
      if (ln_cur_x == ln_tgt_x && ln_cur_y == ln_tgt_y) ln_busy = 1'b0;
      emits = 1'b1;
    end
    pix.x     = ln_cur_x;
    pix.y     = ln_cur_y;
    pix.color = ln_color;
    pix.last  = (ln_cur_x == ln_tgt_x && ln_cur_y == ln_tgt_y);
  endtask

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // Driver: one request per beat, random gaps between beats
  always @(posedge clk_i or negedge rst_ni) begin
    line_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_q.pop_front();
        in_valid_i   <= 1'b1;
        req_type_i   <= nxt.kind;
        x_start_i    <= nxt.xs;
        y_start_i    <= nxt.ys;
        x_end_i      <= nxt.xe;
        y_end_i      <= nxt.ye;
        line_color_i <= nxt.color;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: predict on input beats, check on output beats, random backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_beat  = in_valid_i && in_ready_o;
      out_beat = out_valid_o && out_ready_i;
      if (in_beat) begin
        seen_req.kind  = req_cmd_e'(req_type_i);
        seen_req.xs    = x_start_i;
        seen_req.ys    = y_start_i;
        seen_req.xe    = x_end_i;
        seen_req.ye    = y_end_i;
        seen_req.color = line_color_i;
        raster_advance(seen_req, has_pix, pred_pix);
        if (has_pix) pixel_q.push_back(pred_pix);
      end
      if (out_beat) begin
        got_pix.x     = pixel_x_o;
        got_pix.y     = pixel_y_o;
        got_pix.color = pixel_color_o;
        got_pix.last  = last_o;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel: expected none, got (%0d,%0d) color %0d last %0d",
                   $time, got_pix.x, got_pix.y, got_pix.color, got_pix.last);
          fail_cnt++;
        end else begin
          want_pix = pixel_q.pop_front();
          cmp_field("pixel_x", int'(want_pix.x), int'(got_pix.x));
          cmp_field("pixel_y", int'(want_pix.y), int'(got_pix.y));
          cmp_field("pixel_color", int'(want_pix.color), int'(got_pix.color));
          cmp_field("last", int'(want_pix.last), int'(got_pix.last));
        end
      end
      quiet_cycles <= (in_beat || out_beat) ? 0 : quiet_cycles + 1;
      out_ready_i  <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any beat
  initial begin
    do @(negedge clk_i); while (quiet_cycles < QUIET_LIMIT);
    $display("FAIL line_pixel_stepper_unit");
    $finish;
  end

  // Stimulus builders
  function automatic int rnd_coord();
    logic signed [CW-1:0] v;
    v = CW'($urandom_range(65535));
    return int'(v);
  endfunction

  // Keep the far endpoint inside the coordinate range
  function automatic int fold(input int a, input int d);
    int b;
    b = a + d;
    if (b > 32767 || b < -32768) b = a - d;
    return b;
  endfunction

  task automatic push_start(input int xs, input int ys, input int xe, input int ye,
                            input int color);
    line_req_t r;
    r.kind  = CMD_START;
    r.xs    = CW'(xs);
    r.ys    = CW'(ys);
    r.xe    = CW'(xe);
    r.ye    = CW'(ye);
    r.color = KW'(color);
    req_q.push_back(r);
  endtask

  // Step requests carry random coordinates, which the block ignores
  task automatic push_step(input int n);
    line_req_t r;
    repeat (n) begin
      r.kind  = CMD_STEP;
      r.xs    = CW'($urandom_range(65535));
      r.ys    = CW'($urandom_range(65535));
      r.xe    = CW'($urandom_range(65535));
      r.ye    = CW'($urandom_range(65535));
      r.color = KW'($urandom_range(65535));
      req_q.push_back(r);
    end
  endtask

  task automatic queue_random(input int target);
    int done, pick, len, dx, dy, nsteps, xs, ys, xe, ye, adx, ady;
    done = 0;
    while (done < target) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // stray step, usually with no line in progress
        push_step(1);
        done++;
      end else begin
        xs = rnd_coord();
        ys = rnd_coord();
        if (pick < 14) begin
          // full-range line, abandoned after a few pixels
          xe     = rnd_coord();
          ye     = rnd_coord();
          nsteps = $urandom_range(4);
        end else begin
          len = ($urandom_range(9) == 0) ? 300 : 12;
          dx  = int'($urandom_range(2 * len)) - len;
          dy  = int'($urandom_range(2 * len)) - len;
          xe  = fold(xs, dx);
          ye  = fold(ys, dy);
          adx = (dx < 0) ? -dx : dx;
          ady = (dy < 0) ? -dy : dy;
          nsteps = (adx > ady) ? adx : ady;
          pick = $urandom_range(9);
          if (pick == 0 && nsteps > 0) nsteps = $urandom_range(nsteps - 1);
          else if (pick == 1) nsteps += $urandom_range(3, 1);
        end
        push_start(xs, ys, xe, ye, $urandom_range(65535));
        push_step(nsteps);
        done += 1 + nsteps;
      end
    end
  endtask

  // Hold off new requests until the pipeline and scoreboard are empty
  task automatic wait_drained();
    do @(negedge clk_i); while (req_q.size() != 0 || in_valid_i || pixel_q.size() != 0);
  endtask

  // Main sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle step, single point, extremes, abandon, axis-aligned and octants
    push_step(1);
    push_start(-32768, 32767, -32768, 32767, 16'h0000);
    push_step(1);
    push_start(32767, -32768, -32768, 32767, 16'hFFFF);
    push_step(2);
    push_start(0, 0, 3, 0, 16'hA5A5);
    push_step(4);
    push_start(5, 5, 5, 2, 16'h5A5A);
    push_step(3);
    push_start(0, 0, -1, -3, 16'h0001);
    push_step(3);
    push_start(0, 0, -4, 1, 16'h8000);
    push_step(4);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_cnt == 0 && pixel_q.size() == 0) begin
      $display("PASS line_pixel_stepper_unit");
    end else begin
      $display("FAIL line_pixel_stepper_unit");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lps_pkg.sv
sv/lps_front.sv
sv/lps_queue.sv
sv/lps_back.sv
sv/line_pixel_stepper_unit.sv
dv/tb_line_pixel_stepper_unit.sv
